// ===== sv/mwv_pkg.sv =====
// shared constants for the moving window variance block
`default_nettype none

package mwv_pkg;

  localparam int SAMPLE_W = 8;
  localparam int VAR_W    = 16;
  localparam int VAR_MAX  = 65025;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [VAR_W-1:0]           variance_t;

endpackage

`default_nettype wire

// ===== sv/moving_window_variance.sv =====
// moving window variance top level: sequencer, accumulator and output register
//
//   channel   dir   fields (lsb up)        transfer when
//   s_*       in    tdata: z_sample[7:0]   s_tvalid && s_tready
//   m_*       out   tdata: variance[15:0]  m_tvalid && m_tready
//
// each sample runs through the sequencer in order: a ring walk over the single read port
// that sums the window, a division for the mean, a second ring walk that sums
// the squared deviations, a division for the variance, then the output state
// m_tvalid is registered as the sequencer leaves the output state
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register and the next sample is taken meanwhile, a second finished
// result holds the sequencer until the output register frees
// synchronous reset clears the ring valid flags, write index and control state
`default_nettype none

module moving_window_variance
  import mwv_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [SAMPLE_W-1:0] s_tdata,   // z_sample[7:0]
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [VAR_W-1:0]        m_tdata     // variance[15:0]
);

  localparam int IW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 2);
  localparam int SUMW = SAMPLE_W + $clog2(WINDOW);
  localparam int QW   = $clog2(VAR_MAX * WINDOW + 1);
  localparam int MW   = SAMPLE_W + 1;
  localparam int DW   = SAMPLE_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_MEAN = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_VAR  = 3'd5;
  localparam logic [2:0] S_DIV2 = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]             state;
  logic [CW-1:0]          cnt;
  logic [IW-1:0]          widx;
  logic [IW-1:0]          widx_next;
  logic                   pv;
  logic                   pv2;
  logic                   issue;
  logic                   accept;
  logic signed [SUMW-1:0] sum;
  logic [SUMW-1:0]        sum_mag;
  logic signed [MW-1:0]   mean;
  logic [VAR_W-1:0]       prod_q;
  logic signed [DW-1:0]   dev;
  logic signed [2*DW-1:0] dev_sq;
  logic [QW-1:0]          sq;
  logic [QW-1:0]          div_in;
  logic                   div_start;
  logic                   div_done;
  logic [QW-1:0]          div_q;
  logic [MW-1:0]          q_mean;
  variance_t              var_clamped;
  variance_t              result;
  sample_t                rd_data;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign widx_next = (widx == IW'(WINDOW - 1)) ? '0 : widx + IW'(1);
  assign issue     = ((state == S_SUM) || (state == S_SQ)) && (cnt < CW'(WINDOW));

  mwv_ring #(
    .WINDOW (WINDOW),
    .IW     (IW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_addr (widx_next),
    .wr_data (sample_t'(s_tdata)),
    .rd_en   (issue),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  assign sum_mag   = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign div_start = (state == S_MEAN) || (state == S_VAR);
  assign div_in    = (state == S_MEAN) ? QW'(sum_mag) : sq;

  mwv_div #(
    .WIDTH   (QW),
    .DIVISOR (WINDOW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_mean      = div_q[MW-1:0];
  assign dev         = DW'(rd_data) - DW'(mean);
  assign dev_sq      = dev * dev;
  assign var_clamped = (div_q > QW'(VAR_MAX)) ? VAR_W'(VAR_MAX) : div_q[VAR_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      widx     <= '0;
      pv       <= 1'b0;
      pv2      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pv  <= issue;
      pv2 <= pv && (state == S_SQ);
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            widx  <= widx_next;
            cnt   <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt == CW'(WINDOW)) begin
            state <= S_MEAN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_MEAN: begin
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt == CW'(WINDOW + 1)) begin
            state <= S_VAR;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_VAR: begin
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sum <= '0;
      sq  <= '0;
    end else begin
      if (pv && (state == S_SUM)) begin
        sum <= sum + SUMW'(rd_data);
      end
      if (pv2) begin
        sq <= sq + QW'(prod_q);
      end
    end
    if (pv) begin
      prod_q <= dev_sq[VAR_W-1:0];
    end
    if ((state == S_DIV1) && div_done) begin
      mean <= sum[SUMW-1] ? MW'(-q_mean) : MW'(q_mean);
    end
    if ((state == S_DIV2) && div_done) begin
      result <= var_clamped;
    end
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= result;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mwv_ring.sv =====
// sample ring memory with per-entry valid flags, registered read
`default_nettype none

module mwv_ring
  import mwv_pkg::*;
#(
  parameter int WINDOW = 10,
  parameter int IW     = $clog2(WINDOW)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire sample_t       wr_data,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output sample_t            rd_data
);

  sample_t           mem [WINDOW];
  logic [WINDOW-1:0] valid;
  sample_t           mem_q;
  logic              valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = valid_q ? mem_q : sample_t'(0);

endmodule

`default_nettype wire

// ===== sv/mwv_div.sv =====
// divide by a constant through reciprocal multiplication, quotient and done in the cycle after start
`default_nettype none

module mwv_div #(
  parameter int WIDTH   = 20,
  parameter int DIVISOR = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient
);

  // rounded-up reciprocal, exact for every dividend below 2**WIDTH
  localparam int              SH      = WIDTH + $clog2(DIVISOR);
  localparam int              RECW    = WIDTH + 2;
  localparam int              PW      = WIDTH + RECW;
  localparam logic [63:0]     RECIP64 = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECW-1:0] RECIP   = RECIP64[RECW-1:0];

  logic [PW-1:0] prod;
  logic [PW-1:0] prod_q;

  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_q <= prod;
    end
  end

  assign quotient = WIDTH'(prod_q >> SH);

endmodule

`default_nettype wire
